// ===== design/h264aus_pkg.sv =====
// Shared types and constants for the H.264 access unit splitter.
// Used by h264aus_scan and h264_access_unit_splitter_top; no dependencies.
`timescale 1ns / 1ps

package h264aus_pkg;

  // Lengths and byte positions are 21 bits wide, enough for MAX_CHUNK itself.
  localparam int LEN_W            = 21;
  localparam int MAX_CHUNK        = 1048576;
  localparam int SKIP_AFTER_START = 8;
  localparam int WIN_LEN          = SKIP_AFTER_START + 1;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEC_IS_H264 = 2'd2;

  localparam logic [LEN_W-1:0] BUFFER_SIZE_RST = 21'd65536;

  // NAL unit types of interest.
  localparam logic [4:0] NAL_SLICE     = 5'd1;
  localparam logic [4:0] NAL_IDR       = 5'd5;
  localparam logic [4:0] NAL_SEI       = 5'd6;
  localparam logic [4:0] NAL_SPS       = 5'd7;
  localparam logic [4:0] NAL_PPS       = 5'd8;
  localparam logic [4:0] NAL_SUBSET_SPS = 5'd15;
  localparam logic [4:0] NAL_SLICE_EXT = 5'd20;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_END   = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  // Scan state as it stands after the current beat has been taken in.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] boundary;
    logic             start_found;
    logic             end_found;
  } scan_info_t;

endpackage

// ===== design/h264aus_scan.sv =====
// Start code window and two-phase access unit boundary scan.
// Depends on h264aus_pkg.
`timescale 1ns / 1ps

module h264aus_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [h264aus_pkg::IN_DATA_W-1:0]   data_byte,
  input  logic                                last_byte,
  output h264aus_pkg::scan_info_t             info
);

  logic [7:0]                     win_r   [h264aus_pkg::WIN_LEN];
  logic [7:0]                     win_nxt [h264aus_pkg::WIN_LEN];
  logic [h264aus_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [h264aus_pkg::LEN_W-1:0]  resume_r, resume_nxt;
  logic [h264aus_pkg::LEN_W-1:0]  bound_r, bound_nxt;
  logic                           start_r, start_nxt;
  logic                           end_r, end_nxt;
  h264aus_pkg::phase_t            phase_r, phase_nxt;

  logic [7:0]                     w [h264aus_pkg::WIN_LEN];
  logic [h264aus_pkg::LEN_W-1:0]  cnt_new;
  logic [h264aus_pkg::LEN_W-1:0]  pos;
  logic [4:0]                     nal_type;
  logic                           active;
  logic                           scan_en;
  logic                           prefix;
  logic                           pic_start;
  logic                           boundary;

  // The window as it looks once this byte has been shifted in.
  always_comb begin
    for (int i = 0; i < h264aus_pkg::WIN_LEN - 1; i++) begin
      w[i] = win_r[i+1];
    end
    w[h264aus_pkg::WIN_LEN-1] = data_byte;
  end

  assign active   = step && (cnt_r < h264aus_pkg::LEN_W'(h264aus_pkg::MAX_CHUNK));
  assign cnt_new  = cnt_r + 1'b1;
  assign scan_en  = cnt_new >= h264aus_pkg::LEN_W'(h264aus_pkg::WIN_LEN);
  assign pos      = cnt_new - h264aus_pkg::LEN_W'(h264aus_pkg::WIN_LEN);
  assign nal_type = w[3][4:0];
  assign prefix   = (w[0] == 8'h00) && (w[1] == 8'h00) && (w[2] == 8'h01);
  assign pic_start = (((nal_type == h264aus_pkg::NAL_IDR) ||
                       (nal_type == h264aus_pkg::NAL_SLICE)) && w[4][7]) ||
                     ((nal_type == h264aus_pkg::NAL_SLICE_EXT) && w[7][7]);
  assign boundary = (nal_type == h264aus_pkg::NAL_SUBSET_SPS) ||
                    (nal_type == h264aus_pkg::NAL_SPS) ||
                    (nal_type == h264aus_pkg::NAL_PPS) ||
                    (nal_type == h264aus_pkg::NAL_SEI) || pic_start;

  always_comb begin
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    resume_nxt = resume_r;
    bound_nxt  = bound_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    phase_nxt  = phase_r;
    if (active) begin
      win_nxt = w;
      cnt_nxt = cnt_new;
      if (scan_en) begin
        unique case (phase_r)
          h264aus_pkg::PH_START: begin
            if (prefix && pic_start) begin
              start_nxt  = 1'b1;
              // pos + SKIP_AFTER_START equals the new count minus one.
              resume_nxt = cnt_r;
              phase_nxt  = h264aus_pkg::PH_END;
            end
          end
          h264aus_pkg::PH_END: begin
            if ((pos >= resume_r) && prefix && boundary) begin
              end_nxt   = 1'b1;
              bound_nxt = pos;
              phase_nxt = h264aus_pkg::PH_DONE;
            end
          end
          h264aus_pkg::PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Post-beat view for the result logic.
  assign info.length      = cnt_nxt;
  assign info.boundary    = bound_nxt;
  assign info.start_found = start_nxt;
  assign info.end_found   = end_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      for (int i = 0; i < h264aus_pkg::WIN_LEN; i++) begin
        win_r[i] <= 8'h00;
      end
      cnt_r    <= '0;
      resume_r <= '0;
      bound_r  <= '0;
      start_r  <= 1'b0;
      end_r    <= 1'b0;
      phase_r  <= h264aus_pkg::PH_START;
    end else begin
      win_r    <= win_nxt;
      cnt_r    <= cnt_nxt;
      resume_r <= resume_nxt;
      bound_r  <= bound_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// ===== design/h264_access_unit_splitter_top.sv =====
// Top level of the H.264 Annex B access unit splitter.
// Depends on h264aus_pkg and h264aus_scan.
`timescale 1ns / 1ps

// The block takes one chunk of an H.264 Annex B stream, one byte per beat on
// the in_ channel, with in_tlast marking the final byte of the chunk. Bytes
// without in_tlast produce nothing; the last byte produces exactly one beat on
// the out_ channel carrying the frame length and the status flags.
//
// Throughput is one byte per cycle unless stalled: the start code window, the
// NAL type compares and the result selection sit between the input handshake
// and a single output register. The result beat appears on out_tvalid the
// cycle after the last byte is accepted, and the next chunk can begin at once.
//
// When the receiver stalls, the result stays in the output register and
// in_tready drops only while that register is full and out_tready is low.
//
// The cfg_ channel writes buffer_size, frame_mode and codec_is_h264; it is
// always ready and an unknown index is ignored. Registers are meant to be
// written while the block is idle; the values present when a chunk's last
// byte arrives decide its result.
//
// Reset (rst_n low, synchronous) clears the scan state and the output valid
// and loads the register defaults: 65536 bytes, frame mode on, H.264 on.

module h264_access_unit_splitter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [7:0] data_byte. in_tlast: last_byte.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [h264aus_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                                 in_tlast,
  // out_tdata: [20:0] frame_length, [21] start_found, [22] end_found,
  // [23] oversize, [24] short_chunk, [31:25] zero.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [h264aus_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [h264aus_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [h264aus_pkg::LEN_W-1:0]        cfg_data
);

  localparam int PAD_W = h264aus_pkg::OUT_DATA_W - h264aus_pkg::LEN_W - 4;

  logic [h264aus_pkg::LEN_W-1:0]      buf_size_r;
  logic                               frame_mode_r;
  logic                               h264_r;

  logic                               out_valid_r, out_valid_nxt;
  logic [h264aus_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                               in_fire;
  h264aus_pkg::scan_info_t            info;

  logic [h264aus_pkg::LEN_W-1:0]      res_len;
  logic                               res_start, res_end, res_over, res_eos;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r   <= h264aus_pkg::BUFFER_SIZE_RST;
      frame_mode_r <= 1'b1;
      h264_r       <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        h264aus_pkg::CFG_BUFFER_SIZE:   buf_size_r   <= cfg_data;
        h264aus_pkg::CFG_FRAME_MODE:    frame_mode_r <= cfg_data[0];
        h264aus_pkg::CFG_CODEC_IS_H264: h264_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  h264aus_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .info      (info)
  );

  // Result selection. In frame scan mode an oversize chunk reports its raw
  // length and the oversize flag alone; else a found boundary sets the length.
  // In other modes the length passes through and short chunks flag the end.
  always_comb begin
    res_len   = info.length;
    res_start = 1'b0;
    res_end   = 1'b0;
    res_over  = 1'b0;
    res_eos   = 1'b0;
    if (frame_mode_r && h264_r) begin
      if (info.length > buf_size_r) begin
        res_over = 1'b1;
      end else begin
        res_start = info.start_found;
        res_end   = info.end_found;
        if (info.end_found) begin
          res_len = info.boundary;
        end
      end
    end else begin
      res_eos = (info.length != '0) && (info.length < buf_size_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire && in_tlast) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{PAD_W{1'b0}}, res_eos, res_over, res_end, res_start, res_len};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A last byte always leaves a result waiting in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("last byte accepted without a result");

  // An end boundary is only searched for after a picture start.
  a_end_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[22] && !out_tdata[21]))
    else $error("end_found without start_found");

  // Oversize and the short-chunk flag come from different modes and never
  // pair with the scan flags.
  a_flag_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[23] && (out_tdata[24] || out_tdata[21])))
    else $error("inconsistent result flags");

  // Every chunk holds at least one byte; only a found end may give length 0.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[h264aus_pkg::LEN_W-1:0] != '0) || out_tdata[22])
    else $error("zero frame length without a boundary");

endmodule
